// ===== rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: types and constants used by the top level.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  localparam int unsigned CountBits = 2;

  typedef enum logic [CountBits-1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } root_count_e;

endpackage
`default_nettype wire

// ===== rtl/quadratic_root_solver_unit.sv =====
// Top level of the quadratic root solver: discriminant, root and divider chains.
//
// Order of steps is magnitudes, products, discriminant, root chain, numerators, dividers, output.
// Throughput: one equation per cycle while the output is not stalled; every chain cell holds one equation.
// The square root chain has one cell per root bit, each divider chain one cell per quotient bit.
// Output stalls freeze every stage at once; input is refused while a word waits unread.
// Reset clears the valid bits of all stages; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_unit
  import qrs_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // coef_a, coef_b, coef_c from bit 0 up, padded to bytes
  input  wire logic [((3*WORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // root_first, root_second from bit 0 up, padded to bytes
  output logic [((2*WORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // root_count, saturated from bit 0 up
  output logic [2:0]                               m_axis_tuser
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned MagW  = W + 1;        // |coef| incl. 2^(W-1), also 2|a|
  localparam int unsigned DiscW = 2 * W + 2;    // b^2 + 4|ac| fits
  localparam int unsigned SqW   = W + 1;        // sqrt of DiscW bits
  localparam int unsigned NumW  = W + 2 + F;    // |(-b +/- s)| << F
  localparam int unsigned DenW  = W + 2;        // 2|a|
  localparam int unsigned TagW  = 6;            // quotient signs, spare bit, linear flag, count
  localparam int unsigned OutW  = ((2*W+7)/8)*8;

  // global stall: all cells advance together
  logic adv;
  logic out_full_q;
  assign adv           = !out_full_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- stage 1: magnitudes
  logic [W-1:0] a_w, b_w, c_w;
  assign a_w = s_axis_tdata[W-1:0];
  assign b_w = s_axis_tdata[2*W-1:W];
  assign c_w = s_axis_tdata[3*W-1:2*W];

  logic              v1_q;
  logic              an1_q, bn1_q, cn1_q;
  logic [MagW-1:0]   am1_q, bm1_q, cm1_q;

  function automatic logic [MagW-1:0] mag(input logic [W-1:0] v);
    logic [MagW-1:0] e;
    e = {v[W-1], v};
    return v[W-1] ? MagW'(-e) : e;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      an1_q <= a_w[W-1]; bn1_q <= b_w[W-1]; cn1_q <= c_w[W-1];
      am1_q <= mag(a_w); bm1_q <= mag(b_w); cm1_q <= mag(c_w);
    end
  end

  // ---------------- stage 2: products
  logic              v2_q, an2_q, bn2_q, cn2_q;
  logic [MagW-1:0]   am2_q, bm2_q, cm2_q;
  logic [DiscW-1:0]  p2_q, q2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      an2_q <= an1_q; bn2_q <= bn1_q; cn2_q <= cn1_q;
      am2_q <= am1_q; bm2_q <= bm1_q; cm2_q <= cm1_q;
      p2_q  <= DiscW'(bm1_q) * DiscW'(bm1_q);
      q2_q  <= (DiscW'(am1_q) * DiscW'(cm1_q)) << 2;
    end
  end

  // ---------------- stage 3: discriminant and case
  logic              v3_q, an3_q, bn3_q, lin3_q;
  logic [1:0]        cnt3_q;
  logic [MagW-1:0]   am3_q, bm3_q, cm3_q;
  logic              cn3_q;
  logic [DiscW-1:0]  d3_q;
  logic [1:0]        cnt3_d;
  logic [DiscW-1:0]  d3_d;
  logic              lin3_d;

  always_comb begin
    cnt3_d = CNT_NONE;
    d3_d   = '0;
    lin3_d = 1'b0;
    if (am2_q == '0 && bm2_q == '0) begin
      cnt3_d = (cm2_q == '0) ? CNT_INF : CNT_NONE;
    end else if (am2_q == '0) begin
      cnt3_d = CNT_ONE;
      lin3_d = 1'b1;
    end else if (an2_q != cn2_q && cm2_q != '0) begin
      d3_d   = p2_q + q2_q;
      cnt3_d = CNT_TWO;
    end else if (p2_q < q2_q) begin
      cnt3_d = CNT_NONE;
    end else begin
      d3_d   = p2_q - q2_q;
      cnt3_d = (d3_d == '0) ? CNT_ONE : CNT_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      an3_q <= an2_q; bn3_q <= bn2_q; cn3_q <= cn2_q;
      am3_q <= am2_q; bm3_q <= bm2_q; cm3_q <= cm2_q;
      d3_q  <= d3_d; cnt3_q <= cnt3_d; lin3_q <= lin3_d;
    end
  end

  // ---------------- square root chain; side data travels in a shift line
  logic [SqW-1:0]   sq_root [SqW+1];
  logic [DiscW-1:0] sq_rem  [SqW+1];
  logic [TagW-1:0]  sq_tag  [SqW+1];
  logic             sq_vld  [SqW+1];
  localparam int unsigned SideW = 3 * MagW + 3;
  logic [SideW-1:0] side_q [SqW];

  assign sq_root[0] = '0;
  assign sq_rem[0]  = d3_q;
  assign sq_tag[0]  = {3'b000, lin3_q, cnt3_q};
  assign sq_vld[0]  = v3_q;

  for (genvar i = 0; i < SqW; i++) begin : g_sq
    qrs_sqrt_cell #(
      .DBits(DiscW), .RBits(SqW), .Bit(SqW - 1 - i), .TagW(TagW)
    ) u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni), .en_i(adv), .vld_i(sq_vld[i]),
      .root_i(sq_root[i]), .rem_i(sq_rem[i]), .tag_i(sq_tag[i]),
      .vld_o (sq_vld[i+1]), .root_o(sq_root[i+1]),
      .rem_o (sq_rem[i+1]), .tag_o(sq_tag[i+1])
    );
  end

  for (genvar i = 0; i < SqW; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) side_q[i] <= (i == 0) ? {an3_q, bn3_q, cn3_q, am3_q, bm3_q, cm3_q}
                                     : side_q[(i == 0) ? 0 : i-1];
    end
  end

  // ---------------- stage S: numerators and denominator for the two quotients
  logic [SqW-1:0]  s_root;
  logic [1:0]      s_cnt;
  logic            s_lin, s_an, s_bn, s_cn;
  logic [MagW-1:0] s_am, s_bm, s_cm;
  assign s_root = sq_root[SqW];
  assign {s_lin, s_cnt} = sq_tag[SqW][2:0];
  assign {s_an, s_bn, s_cn, s_am, s_bm, s_cm} = side_q[SqW-1];

  logic [NumW-1:0] n1_d, n2_d;
  logic [DenW-1:0] den_d;
  logic            ng1_d, ng2_d;
  logic [W+1:0]    bx, sx, m1, m2;
  logic            xn1, xn2;

  always_comb begin
    bx  = (W+2)'(s_bm);
    sx  = (s_cnt == CNT_TWO) ? (W+2)'(s_root) : '0;
    // first: -b + s
    if (!s_bn) begin
      if (bx >= sx) begin xn1 = 1'b1; m1 = bx - sx; end
      else begin xn1 = 1'b0; m1 = sx - bx; end
    end else begin
      xn1 = 1'b0; m1 = bx + sx;
    end
    // second: -b - s
    if (!s_bn) begin
      xn2 = 1'b1; m2 = bx + sx;
    end else if (bx >= sx) begin
      xn2 = 1'b0; m2 = bx - sx;
    end else begin
      xn2 = 1'b1; m2 = sx - bx;
    end
    if (s_lin) begin
      n1_d  = NumW'(s_cm) << F;
      den_d = DenW'(s_bm);
      ng1_d = (!s_cn) != s_bn;
    end else begin
      n1_d  = NumW'(m1) << F;
      den_d = DenW'(s_am) << 1;
      ng1_d = xn1 != s_an;
    end
    n2_d  = NumW'(m2) << F;
    ng2_d = xn2 != s_an;
  end

  // ---------------- two divider chains
  logic [NumW-1:0] d1_num [NumW+1], d2_num [NumW+1];
  logic [DenW-1:0] d1_den [NumW+1], d2_den [NumW+1];
  logic [DenW:0]   d1_rem [NumW+1], d2_rem [NumW+1];
  logic [NumW-1:0] d1_quo [NumW+1], d2_quo [NumW+1];
  logic [TagW-1:0] d1_tag [NumW+1], d2_tag [NumW+1];
  logic            d1_vld [NumW+1], d2_vld [NumW+1];

  logic            sv_q;
  logic [NumW-1:0] sn1_q, sn2_q;
  logic [DenW-1:0] sden_q;
  logic [TagW-1:0] stag_q;
  logic            sng2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q <= 1'b0;
    else if (adv) sv_q <= sq_vld[SqW];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sn1_q  <= n1_d; sn2_q <= n2_d; sden_q <= den_d;
      stag_q <= {ng2_d, ng1_d, 1'b0, s_lin, s_cnt};
      sng2_q <= ng2_d;
    end
  end

  assign d1_num[0] = sn1_q; assign d1_den[0] = sden_q; assign d1_rem[0] = '0;
  assign d1_quo[0] = '0;    assign d1_tag[0] = stag_q; assign d1_vld[0] = sv_q;
  assign d2_num[0] = sn2_q; assign d2_den[0] = sden_q; assign d2_rem[0] = '0;
  assign d2_quo[0] = '0;    assign d2_tag[0] = {sng2_q, 5'd0}; assign d2_vld[0] = sv_q;

  for (genvar i = 0; i < NumW; i++) begin : g_div
    qrs_div_cell #(.NBits(NumW), .DBits(DenW), .TagW(TagW)) u_d1 (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .vld_i(d1_vld[i]),
      .num_i(d1_num[i]), .den_i(d1_den[i]), .rem_i(d1_rem[i]), .quo_i(d1_quo[i]),
      .tag_i(d1_tag[i]),
      .vld_o(d1_vld[i+1]), .num_o(d1_num[i+1]), .den_o(d1_den[i+1]),
      .rem_o(d1_rem[i+1]), .quo_o(d1_quo[i+1]), .tag_o(d1_tag[i+1])
    );
    qrs_div_cell #(.NBits(NumW), .DBits(DenW), .TagW(TagW)) u_d2 (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .vld_i(d2_vld[i]),
      .num_i(d2_num[i]), .den_i(d2_den[i]), .rem_i(d2_rem[i]), .quo_i(d2_quo[i]),
      .tag_i(d2_tag[i]),
      .vld_o(d2_vld[i+1]), .num_o(d2_num[i+1]), .den_o(d2_den[i+1]),
      .rem_o(d2_rem[i+1]), .quo_o(d2_quo[i+1]), .tag_o(d2_tag[i+1])
    );
  end

  // ---------------- output stage: sign, saturation, register
  function automatic logic [W-1:0] fix(input logic [NumW-1:0] q, input logic neg,
                                       output logic sat);
    logic [NumW-1:0] lim;
    logic [NumW-1:0] m;
    lim = (NumW'(1) << (W - 1)) - (neg ? NumW'(0) : NumW'(1));
    sat = q > lim;
    m   = sat ? lim : q;
    return neg ? W'(-m) : W'(m);
  endfunction

  logic [1:0]   f_cnt;
  logic         f_lin;
  logic [W-1:0] r1_d, r2_d, r1_raw, r2_raw;
  logic         st1, st2, sat_d;
  assign f_cnt = d1_tag[NumW][1:0];
  assign f_lin = d1_tag[NumW][2];

  always_comb begin
    r1_raw = fix(d1_quo[NumW], d1_tag[NumW][4], st1);
    r2_raw = fix(d2_quo[NumW], d2_tag[NumW][5], st2);
    r1_d   = '0; r2_d = '0; sat_d = 1'b0;
    case (f_cnt)
      CNT_ONE: begin r1_d = r1_raw; sat_d = st1; end
      CNT_TWO: begin r1_d = r1_raw; r2_d = r2_raw; sat_d = st1 | st2; end
      default: ;
    endcase
  end

  logic [W-1:0] r1_q, r2_q;
  logic [1:0]   cnt_q;
  logic         sat_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_full_q <= 1'b0;
    else if (adv) out_full_q <= d1_vld[NumW];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q <= r1_d; r2_q <= r2_d; cnt_q <= f_cnt; sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_full_q;
  assign m_axis_tdata  = OutW'({r2_q, r1_q});
  assign m_axis_tuser  = {sat_q, cnt_q};

  // f_lin only qualifies counts; a linear case never has two roots
  always_ff @(posedge clk_i) begin
    if (rst_ni && adv && d1_vld[NumW] && f_lin)
      assert (f_cnt == CNT_ONE) else $error("linear root with bad count");
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_zero2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] != CNT_TWO |-> m_axis_tdata[2*W-1:W] == '0)
    else $error("unused second root not zero");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] == CNT_NONE || m_axis_tuser[1:0] == CNT_INF)
    |-> !m_axis_tuser[2] && m_axis_tdata[W-1:0] == '0)
    else $error("no-root word carries data");

endmodule
`default_nettype wire

// ===== rtl/qrs_sqrt_cell.sv =====
// One cell of the integer square root chain: decides one root bit per cycle while en_i is high.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell #(
  parameter int unsigned DBits = 64,
  parameter int unsigned RBits = 32,
  parameter int unsigned Bit   = 0,
  parameter int unsigned TagW  = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire logic [RBits-1:0] root_i,
  input  wire logic [DBits-1:0] rem_i,
  input  wire logic [TagW-1:0]  tag_i,
  output logic                  vld_o,
  output logic [RBits-1:0]      root_o,
  output logic [DBits-1:0]      rem_o,
  output logic [TagW-1:0]       tag_o
);

  // Restoring method: trial = (4*root + 1) << (2*Bit) against remainder.
  logic [DBits+1:0] trial;
  logic [DBits+1:0] rem_ext;
  logic             take;
  logic [RBits-1:0] root_d;
  logic [DBits-1:0] rem_d;
  logic [DBits+1:0] base;

  always_comb begin
    base    = {{(DBits+2-RBits){1'b0}}, root_i};
    trial   = ((base << 2) | (DBits+2)'(1)) << (2 * Bit);
    rem_ext = {2'b00, rem_i};
    take    = (rem_ext >= trial);
    rem_d   = take ? DBits'(rem_ext - trial) : rem_i;
    root_d  = (root_i << 1) | RBits'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_o <= root_d;
      rem_o  <= rem_d;
      tag_o  <= tag_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qrs_div_cell.sv =====
// One cell of the restoring divider chain: retires one quotient bit per cycle while en_i is high.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell #(
  parameter int unsigned NBits = 64,
  parameter int unsigned DBits = 34,
  parameter int unsigned TagW  = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire logic [NBits-1:0] num_i,
  input  wire logic [DBits-1:0] den_i,
  input  wire logic [DBits:0]   rem_i,
  input  wire logic [NBits-1:0] quo_i,
  input  wire logic [TagW-1:0]  tag_i,
  output logic                  vld_o,
  output logic [NBits-1:0]      num_o,
  output logic [DBits-1:0]      den_o,
  output logic [DBits:0]        rem_o,
  output logic [NBits-1:0]      quo_o,
  output logic [TagW-1:0]       tag_o
);

  // num shifts left, its top bit feeds the partial remainder
  logic [DBits+1:0] sh;
  logic             take;

  always_comb begin
    sh   = {rem_i, num_i[NBits-1]};
    take = (sh >= {2'b00, den_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_i << 1;
      den_o <= den_i;
      rem_o <= take ? (DBits+1)'(sh - {2'b00, den_i}) : sh[DBits:0];
      quo_o <= {quo_i[NBits-2:0], take};
      tag_o <= tag_i;
    end
  end

endmodule
`default_nettype wire
